@@ hw/rtl/afxcp_pkg.sv @@
`default_nettype none

package afxcp_pkg;

  // Parameter defaults
  localparam int unsigned MaxPayloadDef = 256;
  localparam int unsigned DescCharsDef  = 5;

  // Widths fixed by the item fields and registers
  localparam int unsigned ByteW   = 8;
  localparam int unsigned HdrW    = 40;
  localparam int unsigned EventW  = 3;
  localparam int unsigned KindW   = 2;
  localparam int unsigned PlenW   = 9;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgAddrW = 6;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned OutDataW = 24;

  // Event codes
  typedef enum logic [EventW-1:0] {
    EV_NONE     = 3'd0,
    EV_PAYLOAD  = 3'd1,
    EV_GOOD     = 3'd2,
    EV_BAD      = 3'd3,
    EV_REJECT   = 3'd4,
    EV_OVERFLOW = 3'd5
  } event_e;

  // Message kinds
  localparam logic [KindW-1:0] KIND_IMU = 2'd0;
  localparam logic [KindW-1:0] KIND_GPS = 2'd1;
  localparam logic [KindW-1:0] KIND_INS = 2'd2;

  // Register map, one register per 8-byte slot
  typedef enum logic [CfgIdxW-1:0] {
    REG_START_CHAR = 3'd0,
    REG_FIELD_SEP  = 3'd1,
    REG_DATA_END   = 3'd2,
    REG_FRAME_END  = 3'd3,
    REG_IMU_HDR    = 3'd4,
    REG_GPS_HDR    = 3'd5,
    REG_GPS2_HDR   = 3'd6,
    REG_INS_HDR    = 3'd7
  } reg_idx_e;

  // Reset values
  localparam logic [ByteW-1:0] StartCharRst = 8'd35;
  localparam logic [ByteW-1:0] FieldSepRst  = 8'd44;
  localparam logic [ByteW-1:0] DataEndRst   = 8'd42;
  localparam logic [ByteW-1:0] FrameEndRst  = 8'd13;
  localparam logic [HdrW-1:0]  ImuHdrRst    = 40'd280519855445;
  localparam logic [HdrW-1:0]  GpsHdrRst    = 40'd280519725139;
  localparam logic [HdrW-1:0]  Gps2HdrRst   = 40'd280519725106;
  localparam logic [HdrW-1:0]  InsHdrRst    = 40'd280519855699;

  // Configuration seen by the parser
  typedef struct packed {
    logic [ByteW-1:0] start_char;
    logic [ByteW-1:0] field_sep;
    logic [ByteW-1:0] data_end;
    logic [ByteW-1:0] frame_end;
    logic [HdrW-1:0]  imu_hdr;
    logic [HdrW-1:0]  gps_hdr;
    logic [HdrW-1:0]  gps2_hdr;
    logic [HdrW-1:0]  ins_hdr;
  } cfg_t;

  // Decoded hex digit: ok flag plus nibble (0 when not a digit)
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [ByteW-1:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/afxcp_cfg_regs.sv @@
`default_nettype none

module afxcp_cfg_regs
  import afxcp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [CfgDataW-1:0] pwdata,
  output      logic [CfgDataW-1:0] prdata,
  output      logic                pready,
  output      cfg_t                cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[CfgAddrW-1:CfgAddrW-CfgIdxW]);
  assign cfg_o  = cfg_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_char <= StartCharRst;
      cfg_q.field_sep  <= FieldSepRst;
      cfg_q.data_end   <= DataEndRst;
      cfg_q.frame_end  <= FrameEndRst;
      cfg_q.imu_hdr    <= ImuHdrRst;
      cfg_q.gps_hdr    <= GpsHdrRst;
      cfg_q.gps2_hdr   <= Gps2HdrRst;
      cfg_q.ins_hdr    <= InsHdrRst;
    end else if (wr_en) begin
      unique case (idx)
        REG_START_CHAR: cfg_q.start_char <= pwdata[ByteW-1:0];
        REG_FIELD_SEP:  cfg_q.field_sep  <= pwdata[ByteW-1:0];
        REG_DATA_END:   cfg_q.data_end   <= pwdata[ByteW-1:0];
        REG_FRAME_END:  cfg_q.frame_end  <= pwdata[ByteW-1:0];
        REG_IMU_HDR:    cfg_q.imu_hdr    <= pwdata[HdrW-1:0];
        REG_GPS_HDR:    cfg_q.gps_hdr    <= pwdata[HdrW-1:0];
        REG_GPS2_HDR:   cfg_q.gps2_hdr   <= pwdata[HdrW-1:0];
        REG_INS_HDR:    cfg_q.ins_hdr    <= pwdata[HdrW-1:0];
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      REG_START_CHAR: prdata = CfgDataW'(cfg_q.start_char);
      REG_FIELD_SEP:  prdata = CfgDataW'(cfg_q.field_sep);
      REG_DATA_END:   prdata = CfgDataW'(cfg_q.data_end);
      REG_FRAME_END:  prdata = CfgDataW'(cfg_q.frame_end);
      REG_IMU_HDR:    prdata = CfgDataW'(cfg_q.imu_hdr);
      REG_GPS_HDR:    prdata = CfgDataW'(cfg_q.gps_hdr);
      REG_GPS2_HDR:   prdata = CfgDataW'(cfg_q.gps2_hdr);
      REG_INS_HDR:    prdata = CfgDataW'(cfg_q.ins_hdr);
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/afxcp_in_stage.sv @@
`default_nettype none

module afxcp_in_stage
  import afxcp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output      logic             in_ready_o,
  input  wire logic [ByteW-1:0] in_byte_i,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      logic [ByteW-1:0] out_byte_o
);

  logic             valid_q;
  logic [ByteW-1:0] byte_q;

  // Register refills whenever empty or being drained
  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/afxcp_parse_core.sv @@
`default_nettype none

module afxcp_parse_core
  import afxcp_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MaxPayloadDef,
  parameter int unsigned DESC_CHARS  = DescCharsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cfg_t              cfg_i,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire logic [ByteW-1:0]  in_byte_i,
  output      logic              res_valid_o,
  input  wire logic              res_ready_i,
  output      event_e            res_event_o,
  output      logic [ByteW-1:0]  res_byte_o,
  output      logic [KindW-1:0]  res_kind_o,
  output      logic [PlenW-1:0]  res_len_o
);

  localparam int unsigned DescW = 8 * DESC_CHARS;
  localparam int unsigned DcntW = $clog2(DESC_CHARS + 1);
  localparam int unsigned PcntW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [DcntW-1:0] DescFull = DcntW'(DESC_CHARS);
  localparam logic [PcntW-1:0] PayMax   = PcntW'(MAX_PAYLOAD);

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_DESC = 2'd1,
    PH_DATA = 2'd2,
    PH_SUM  = 2'd3
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [ByteW-1:0]  xor_q, xor_d;
  logic [DescW-1:0]  desc_q, desc_d;
  logic [DcntW-1:0]  dcnt_q, dcnt_d;
  logic [KindW-1:0]  kind_q, kind_d;
  logic [PcntW-1:0]  pcnt_q, pcnt_d;
  logic [1:0]        digits_q, digits_d;
  logic [ByteW-1:0]  rsum_q, rsum_d;
  logic              hexerr_q, hexerr_d;

  logic              res_valid_q;
  event_e            ev_q, ev_d;
  logic [ByteW-1:0]  pbyte_q, pbyte_d;

  logic              step;
  logic [DescW+7:0]  desc_shift;
  logic [DescW+HdrW-1:0] imu_x, gps_x, gps2_x, ins_x;
  logic              full, m_imu, m_gps, m_ins;
  logic [PcntW+PlenW-1:0] len_x;
  hex_t              hx;

  assign in_ready_o = !res_valid_q || res_ready_i;
  assign step       = in_valid_i && in_ready_o;

  // Descriptor compare against low DescW bits of each header word
  assign desc_shift = {desc_q, in_byte_i};
  assign imu_x  = {{DescW{1'b0}}, cfg_i.imu_hdr};
  assign gps_x  = {{DescW{1'b0}}, cfg_i.gps_hdr};
  assign gps2_x = {{DescW{1'b0}}, cfg_i.gps2_hdr};
  assign ins_x  = {{DescW{1'b0}}, cfg_i.ins_hdr};
  assign full   = (dcnt_q == DescFull);
  assign m_imu  = full && (desc_q == imu_x[DescW-1:0]);
  assign m_gps  = full && ((desc_q == gps_x[DescW-1:0]) || (desc_q == gps2_x[DescW-1:0]));
  assign m_ins  = full && (desc_q == ins_x[DescW-1:0]);
  assign hx     = hex_decode(in_byte_i);

  // Next-state logic for one received byte
  always_comb begin
    phase_d  = phase_q;
    xor_d    = xor_q;
    desc_d   = desc_q;
    dcnt_d   = dcnt_q;
    kind_d   = kind_q;
    pcnt_d   = pcnt_q;
    digits_d = digits_q;
    rsum_d   = rsum_q;
    hexerr_d = hexerr_q;
    ev_d     = EV_NONE;
    pbyte_d  = '0;
    unique case (phase_q)
      PH_HUNT: begin
        if (in_byte_i == cfg_i.start_char) begin
          xor_d    = '0;
          desc_d   = '0;
          dcnt_d   = '0;
          kind_d   = KIND_IMU;
          pcnt_d   = '0;
          digits_d = '0;
          rsum_d   = '0;
          hexerr_d = 1'b0;
          phase_d  = PH_DESC;
        end
      end
      PH_DESC: begin
        if (in_byte_i == cfg_i.field_sep) begin
          xor_d  = xor_q ^ in_byte_i;
          pcnt_d = '0;
          priority if (m_imu) begin
            kind_d  = KIND_IMU;
            phase_d = PH_DATA;
          end else if (m_gps) begin
            kind_d  = KIND_GPS;
            phase_d = PH_DATA;
          end else if (m_ins) begin
            kind_d  = KIND_INS;
            phase_d = PH_DATA;
          end else begin
            ev_d    = EV_REJECT;
            phase_d = PH_HUNT;
          end
        end else if (dcnt_q >= DescFull) begin
          ev_d    = EV_OVERFLOW;
          phase_d = PH_HUNT;
        end else begin
          desc_d = desc_shift[DescW-1:0];
          dcnt_d = dcnt_q + 1'b1;
          xor_d  = xor_q ^ in_byte_i;
        end
      end
      PH_DATA: begin
        if (in_byte_i == cfg_i.data_end) begin
          phase_d  = PH_SUM;
          digits_d = '0;
          rsum_d   = '0;
          hexerr_d = 1'b0;
        end else if (pcnt_q >= PayMax) begin
          ev_d    = EV_OVERFLOW;
          phase_d = PH_HUNT;
        end else begin
          pcnt_d  = pcnt_q + 1'b1;
          xor_d   = xor_q ^ in_byte_i;
          ev_d    = EV_PAYLOAD;
          pbyte_d = in_byte_i;
        end
      end
      PH_SUM: begin
        if (in_byte_i == cfg_i.frame_end) begin
          ev_d    = (digits_q == 2'd2 && !hexerr_q && rsum_q == xor_q) ? EV_GOOD : EV_BAD;
          phase_d = PH_HUNT;
        end else if (digits_q >= 2'd2) begin
          hexerr_d = 1'b1;
        end else begin
          if (!hx.ok) hexerr_d = 1'b1;
          rsum_d   = {rsum_q[3:0], hx.val};
          digits_d = digits_q + 1'b1;
        end
      end
    endcase
  end

  // Frame state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      xor_q       <= '0;
      desc_q      <= '0;
      dcnt_q      <= '0;
      kind_q      <= '0;
      pcnt_q      <= '0;
      digits_q    <= '0;
      rsum_q      <= '0;
      hexerr_q    <= 1'b0;
      res_valid_q <= 1'b0;
      ev_q        <= EV_NONE;
      pbyte_q     <= '0;
    end else begin
      if (in_ready_o) begin
        res_valid_q <= in_valid_i;
      end
      if (step) begin
        phase_q  <= phase_d;
        xor_q    <= xor_d;
        desc_q   <= desc_d;
        dcnt_q   <= dcnt_d;
        kind_q   <= kind_d;
        pcnt_q   <= pcnt_d;
        digits_q <= digits_d;
        rsum_q   <= rsum_d;
        hexerr_q <= hexerr_d;
        ev_q     <= ev_d;
        pbyte_q  <= pbyte_d;
      end
    end
  end

  // Kind and length report the state left by the item
  assign len_x       = {{PlenW{1'b0}}, pcnt_q};
  assign res_valid_o = res_valid_q;
  assign res_event_o = ev_q;
  assign res_byte_o  = pbyte_q;
  assign res_kind_o  = kind_q;
  assign res_len_o   = len_x[PlenW-1:0];

endmodule

`default_nettype wire

@@ hw/rtl/ascii_frame_xor_checksum_parser_unit.sv @@
`default_nettype none

// ASCII frame parser with XOR checksum. One received byte per item enters on
// s_axis; every item gives exactly one result item on m_axis, carrying an event
// code in tuser plus the payload byte, message kind and payload length so far.
// A frame opens on the start character, a descriptor of DESC_CHARS bytes up to
// the field separator selects the message kind (IMU, GPS/GP2 or INS), payload
// bytes up to the data end character are passed out, and two hex digits up to
// the frame end character are checked against the XOR of descriptor, separator
// and payload. Throughput is one item per clock unless m_axis stalls; bytes
// pass the input register, then the parse result register. Registers sit
// at byte address 8*i on the APB port and should be written only while idle.

module ascii_frame_xor_checksum_parser_unit
  import afxcp_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MaxPayloadDef,
  parameter int unsigned DESC_CHARS  = DescCharsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // APB configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [CfgDataW-1:0] pwdata,
  output      logic [CfgDataW-1:0] prdata,
  output      logic                pready,
  // Input stream
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  input  wire logic [ByteW-1:0]    s_axis_tdata,   // [7:0] rx_byte
  // Result stream
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output      logic [OutDataW-1:0] m_axis_tdata,   // [7:0] payload_byte, [9:8] msg_kind,
                                                   // [18:10] payload_length, [23:19] zero
  output      logic [EventW-1:0]   m_axis_tuser    // [2:0] event_res
);

  cfg_t             cfg;
  logic             st_valid, st_ready;
  logic [ByteW-1:0] st_byte;
  event_e           res_event;
  logic [ByteW-1:0] res_byte;
  logic [KindW-1:0] res_kind;
  logic [PlenW-1:0] res_len;

  afxcp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  afxcp_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .out_valid_o (st_valid),
    .out_ready_i (st_ready),
    .out_byte_o  (st_byte)
  );

  afxcp_parse_core #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .DESC_CHARS  (DESC_CHARS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (st_valid),
    .in_ready_o  (st_ready),
    .in_byte_i   (st_byte),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_event_o (res_event),
    .res_byte_o  (res_byte),
    .res_kind_o  (res_kind),
    .res_len_o   (res_len)
  );

  // Pack result item
  assign m_axis_tdata = {{(OutDataW - ByteW - KindW - PlenW){1'b0}}, res_len, res_kind, res_byte};
  assign m_axis_tuser = res_event;

  // A payload byte is only reported with a payload event
  a_byte_only_on_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != EV_PAYLOAD) |-> (m_axis_tdata[ByteW-1:0] == '0))
    else $error("payload byte set without payload event");

  // A payload event always follows at least one counted payload byte
  a_len_on_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == EV_PAYLOAD) |->
      (m_axis_tdata[ByteW+KindW+PlenW-1:ByteW+KindW] != '0))
    else $error("payload event with zero length");

  // Input can only stall when the result side is full and held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

  // Event codes stay within the defined set
  a_event_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser <= EV_OVERFLOW))
    else $error("undefined event code");

endmodule

`default_nettype wire
